### sv/apu_pkg.sv
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types and constants of the Adam parameter update block.
// ----------------------------------------------------------------------------
`default_nettype none

package apu_pkg;

  localparam int FRAC_BITS = 24;
  localparam int CNT_W     = 16;

  localparam logic [24:0] ONE_Q    = 25'h100_0000;
  localparam logic [47:0] V_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [34:0] STEP_CAP = 35'h4_0000_0000;

  typedef enum logic [2:0] {
    REG_LR    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_EPS   = 3'd3,
    REG_THR   = 3'd4,
    REG_MAX   = 3'd5,
    REG_START = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_M1, OP_M2, OP_M3,
    OP_G1, OP_G2, OP_G3,
    OP_V1, OP_V2, OP_V3, OP_V4, OP_V5,
    OP_P1, OP_P2,
    OP_DIV_MH, OP_GET_MH,
    OP_DIV_VH, OP_GET_VH,
    OP_SQRT, OP_GET_ROOT,
    OP_DIV_Q, OP_GET_Q,
    OP_S1, OP_S2, OP_S3, OP_GET_F,
    OP_UPD, OP_HOLD
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK,
    ST_M1, ST_M2, ST_M3,
    ST_G1, ST_G2, ST_G3,
    ST_V1, ST_V2, ST_V3, ST_V4, ST_V5,
    ST_P1, ST_P2,
    ST_DIV_MH, ST_WAIT_MH,
    ST_DIV_VH, ST_WAIT_VH,
    ST_SQRT, ST_WAIT_SQ,
    ST_DIV_Q, ST_WAIT_Q,
    ST_S1, ST_S2, ST_S3, ST_WAIT_F,
    ST_UPD, ST_HOLD
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic busy;
  } stat_t;

  typedef struct packed {
    logic       start;
    logic       sqrt_mode;
    logic [6:0] steps;
  } iter_req_t;

endpackage

`default_nettype wire

### sv/apu_divsqrt.sv
// ----------------------------------------------------------------------------
// apu_divsqrt
// Shared bit-serial unit: restoring division one quotient bit per cycle,
// or integer square root one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_divsqrt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire apu_pkg::iter_req_t req,
  input  wire logic [32:0]        rem_init,
  input  wire logic [63:0]        bits,
  input  wire logic [32:0]        divisor,
  output logic                    busy,
  output logic [55:0]             res,
  output logic [32:0]             rem
);
  import apu_pkg::*;

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        mode_r, mode_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [55:0] res_r, res_nxt;
  logic [32:0] dsr_r, dsr_nxt;

  logic [33:0] dcat;
  logic [34:0] ddiff;
  logic [35:0] scat;
  logic [36:0] sdiff;

  always_comb begin
    dcat  = {rem_r[32:0], sh_r[63]};
    ddiff = {1'b0, dcat} - {2'b0, dsr_r};
    scat  = {rem_r, sh_r[63:62]};
    sdiff = {1'b0, scat} - {3'b0, res_r[31:0], 2'b01};
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    res_nxt  = res_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      mode_nxt = req.sqrt_mode;
      rem_nxt  = {1'b0, rem_init};
      sh_nxt   = bits;
      res_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
      if (mode_r) begin
        sh_nxt = {sh_r[61:0], 2'b00};
        if (!sdiff[36]) begin
          rem_nxt = sdiff[33:0];
          res_nxt = {res_r[54:0], 1'b1};
        end else begin
          rem_nxt = scat[33:0];
          res_nxt = {res_r[54:0], 1'b0};
        end
      end else begin
        sh_nxt = {sh_r[62:0], 1'b0};
        if (!ddiff[34]) begin
          rem_nxt = {1'b0, ddiff[32:0]};
          res_nxt = {res_r[54:0], 1'b1};
        end else begin
          rem_nxt = {1'b0, dcat[32:0]};
          res_nxt = {res_r[54:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    res_r <= res_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy = busy_r;
  assign res  = res_r;
  assign rem  = rem_r[32:0];

endmodule

`default_nettype wire

### sv/apu_dp.sv
// ----------------------------------------------------------------------------
// apu_dp
// Datapath: configuration registers, optimizer state, one shared multiplier,
// an accumulator and the shared divide / square root unit.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire apu_pkg::cmd_t      cmd,
  output apu_pkg::stat_t          stat,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic [31:0]        in_grad,
  input  wire logic               in_rst,
  output logic [31:0]             res_position,
  output logic [15:0]             res_steps,
  output logic                    res_converged,
  output logic                    res_done
);
  import apu_pkg::*;

  // configuration
  logic [23:0] lr_r, b1_r, b2_r, eps_r, thr_r;
  logic [15:0] max_r;
  logic [31:0] start_r;

  // optimizer state
  logic signed [31:0] pos_r, m_r, g_r;
  logic [47:0]        v_r;
  logic [23:0]        p1_r, p2_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               fin_r;

  // working registers
  logic signed [75:0] acc_r;
  logic [46:0]        sq_r;
  logic [55:0]        mh_r, q_r;
  logic [47:0]        vh_r;
  logic [32:0]        den_r, r_r;
  logic               cap_r;
  logic [34:0]        step_r;

  // result
  logic [31:0] out_pos_r;
  logic [15:0] out_cnt_r;
  logic        out_conv_r, out_done_r;

  logic signed [33:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [59:0] prod;
  logic signed [75:0] pext, psh16, psh24;
  logic [31:0]        gm, mm;
  logic [24:0]        d1, d2, cb1, cb2;
  logic [23:0]        eps_eff;
  logic signed [75:0] ash;
  logic [59:0]        p_round;
  logic [75:0]        stp_full;
  logic signed [36:0] pos_new;
  logic [CNT_W-1:0]   cnt_inc;
  logic               conv;

  iter_req_t   ireq;
  logic [32:0] i_rem_init, i_divisor;
  logic [63:0] i_bits;
  logic        i_busy;
  logic [55:0] i_res;
  logic [32:0] i_rem;

  always_comb begin
    gm      = g_r[31] ? 32'(-g_r) : 32'(g_r);
    mm      = m_r[31] ? 32'(-m_r) : 32'(m_r);
    cb1     = ONE_Q - {1'b0, b1_r};
    cb2     = ONE_Q - {1'b0, b2_r};
    d1      = ONE_Q - {1'b0, p1_r};
    d2      = ONE_Q - {1'b0, p2_r};
    eps_eff = (eps_r == 24'd0) ? 24'd1 : eps_r;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_M1: begin mul_a = {{2{m_r[31]}}, m_r};   mul_b = {2'b0, b1_r}; end
      OP_M2: begin mul_a = {{2{g_r[31]}}, g_r};   mul_b = {1'b0, cb1};  end
      OP_G1: begin mul_a = {2'b0, gm};            mul_b = {10'b0, gm[31:16]}; end
      OP_G2: begin mul_a = {2'b0, gm};            mul_b = {10'b0, gm[15:0]};  end
      OP_V1: begin mul_a = {10'b0, v_r[47:24]};   mul_b = {2'b0, b2_r}; end
      OP_V2: begin mul_a = {10'b0, v_r[23:0]};    mul_b = {2'b0, b2_r}; end
      OP_V3: begin mul_a = {11'b0, sq_r[46:24]};  mul_b = {1'b0, cb2};  end
      OP_V4: begin mul_a = {10'b0, sq_r[23:0]};   mul_b = {1'b0, cb2};  end
      OP_P1: begin mul_a = {10'b0, p1_r};         mul_b = {2'b0, b1_r}; end
      OP_P2: begin mul_a = {10'b0, p2_r};         mul_b = {2'b0, b2_r}; end
      OP_S1: begin mul_a = {2'b0, q_r[55:24]};    mul_b = {2'b0, lr_r}; end
      OP_S2: begin mul_a = {10'b0, q_r[23:0]};    mul_b = {2'b0, lr_r}; end
      OP_S3: begin mul_a = {1'b0, r_r};           mul_b = {2'b0, lr_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    prod    = mul_a * mul_b;
    pext    = {{16{prod[59]}}, prod};
    psh16   = {pext[59:0], 16'b0};
    psh24   = {pext[51:0], 24'b0};
    ash     = acc_r >>> FRAC_BITS;
    p_round = prod + 60'h80_0000;
    stp_full = 76'(acc_r) + {52'b0, i_res[23:0]};
    pos_new = m_r[31] ? (37'(pos_r) + $signed({2'b0, step_r}))
                      : (37'(pos_r) - $signed({2'b0, step_r}));
    cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    conv    = gm < {8'b0, thr_r};
  end

  // shared divide / square root requests
  always_comb begin
    ireq       = '0;
    i_rem_init = '0;
    i_bits     = '0;
    i_divisor  = '0;
    unique case (cmd.op)
      OP_DIV_MH: begin
        ireq       = '{start: 1'b1, sqrt_mode: 1'b0, steps: 7'd56};
        i_bits     = {mm, 32'b0};
        i_divisor  = {8'b0, d1};
      end
      OP_DIV_VH: begin
        ireq       = '{start: 1'b1, sqrt_mode: 1'b0, steps: 7'd48};
        i_rem_init = {9'b0, v_r[47:24]};
        i_bits     = {v_r[23:0], 40'b0};
        i_divisor  = {8'b0, d2};
      end
      OP_SQRT: begin
        ireq       = '{start: 1'b1, sqrt_mode: 1'b1, steps: 7'd32};
        i_bits     = {vh_r, 16'b0};
      end
      OP_DIV_Q: begin
        ireq       = '{start: 1'b1, sqrt_mode: 1'b0, steps: 7'd56};
        i_bits     = {mh_r, 8'b0};
        i_divisor  = den_r;
      end
      OP_S3: begin
        ireq       = '{start: 1'b1, sqrt_mode: 1'b0, steps: 7'd24};
        i_rem_init = prod[56:24];
        i_bits     = {prod[23:0], 40'b0};
        i_divisor  = den_r;
      end
      default: begin
        ireq = '0;
      end
    endcase
  end

  apu_divsqrt u_divsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (ireq),
    .rem_init (i_rem_init),
    .bits     (i_bits),
    .divisor  (i_divisor),
    .busy     (i_busy),
    .res      (i_res),
    .rem      (i_rem)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= 24'd16777;
      b1_r    <= 24'd15099494;
      b2_r    <= 24'd16760439;
      eps_r   <= 24'd1;
      thr_r   <= 24'd17;
      max_r   <= 16'd1000;
      start_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LR:    lr_r    <= cfg_wdata[23:0];
        REG_B1:    b1_r    <= cfg_wdata[23:0];
        REG_B2:    b2_r    <= cfg_wdata[23:0];
        REG_EPS:   eps_r   <= cfg_wdata[23:0];
        REG_THR:   thr_r   <= cfg_wdata[23:0];
        REG_MAX:   max_r   <= cfg_wdata[15:0];
        REG_START: start_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // optimizer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      m_r   <= '0;
      v_r   <= '0;
      p1_r  <= 24'hFF_FFFF;
      p2_r  <= 24'hFF_FFFF;
      cnt_r <= '0;
      fin_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_ACCEPT: begin
          if (in_rst) begin
            pos_r <= start_r;
            m_r   <= '0;
            v_r   <= '0;
            p1_r  <= 24'hFF_FFFF;
            p2_r  <= 24'hFF_FFFF;
            cnt_r <= '0;
            fin_r <= 1'b0;
          end
        end
        OP_M3: begin
          if (ash > 76'sd2147483647) begin
            m_r <= 32'sh7FFF_FFFF;
          end else if (ash < -76'sd2147483648) begin
            m_r <= 32'sh8000_0000;
          end else begin
            m_r <= ash[31:0];
          end
        end
        OP_V5: v_r <= (ash > $signed({28'b0, V_MAX})) ? V_MAX : ash[47:0];
        OP_P1: p1_r <= p_round[47:24];
        OP_P2: p2_r <= p_round[47:24];
        OP_UPD: begin
          if (pos_new > 37'sd2147483647) begin
            pos_r <= 32'sh7FFF_FFFF;
          end else if (pos_new < -37'sd2147483648) begin
            pos_r <= 32'sh8000_0000;
          end else begin
            pos_r <= pos_new[31:0];
          end
          cnt_r <= cnt_inc;
          fin_r <= conv || (cnt_inc >= max_r);
        end
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT:   g_r   <= in_grad;
      OP_M1:       acc_r <= pext + 76'sh80_0000;
      OP_M2:       acc_r <= acc_r + pext;
      OP_G1:       acc_r <= psh16;
      OP_G2:       acc_r <= acc_r + pext + 76'sh8000;
      OP_G3:       sq_r  <= acc_r[62:16];
      OP_V1:       acc_r <= psh24 + 76'sh80_0000;
      OP_V2:       acc_r <= acc_r + pext;
      OP_V3:       acc_r <= acc_r + psh24;
      OP_V4:       acc_r <= acc_r + pext;
      OP_GET_MH:   mh_r  <= i_res;
      OP_GET_VH:   vh_r  <= ({1'b0, v_r[47:24]} >= d2) ? V_MAX : i_res[47:0];
      OP_GET_ROOT: den_r <= {1'b0, i_res[31:0]} + {9'b0, eps_eff};
      OP_GET_Q: begin
        q_r <= i_res;
        r_r <= i_rem;
      end
      OP_S1: begin
        cap_r <= (prod >= 60'sd1024);
        acc_r <= psh24;
      end
      OP_S2:       acc_r <= acc_r + pext;
      OP_GET_F:    step_r <= (cap_r || stp_full > {41'b0, STEP_CAP}) ?
                             STEP_CAP : stp_full[34:0];
      OP_UPD: begin
        out_pos_r  <= (pos_new > 37'sd2147483647) ? 32'h7FFF_FFFF :
                      (pos_new < -37'sd2147483648) ? 32'h8000_0000 : pos_new[31:0];
        out_cnt_r  <= cnt_inc;
        out_conv_r <= conv;
        out_done_r <= conv || (cnt_inc >= max_r);
      end
      OP_HOLD: begin
        out_pos_r  <= pos_r;
        out_cnt_r  <= cnt_r;
        out_conv_r <= 1'b0;
        out_done_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign stat          = '{fin: fin_r, busy: i_busy};
  assign res_position  = out_pos_r;
  assign res_steps     = out_cnt_r;
  assign res_converged = out_conv_r;
  assign res_done      = out_done_r;

endmodule

`default_nettype wire

### sv/apu_ctrl.sv
// ----------------------------------------------------------------------------
// apu_ctrl
// Controller: sequences one update through the datapath and owns the
// input and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output apu_pkg::cmd_t       cmd,
  input  wire apu_pkg::stat_t stat
);
  import apu_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = stat.fin ? ST_HOLD : ST_M1;
      ST_M1:      state_nxt = ST_M2;
      ST_M2:      state_nxt = ST_M3;
      ST_M3:      state_nxt = ST_G1;
      ST_G1:      state_nxt = ST_G2;
      ST_G2:      state_nxt = ST_G3;
      ST_G3:      state_nxt = ST_V1;
      ST_V1:      state_nxt = ST_V2;
      ST_V2:      state_nxt = ST_V3;
      ST_V3:      state_nxt = ST_V4;
      ST_V4:      state_nxt = ST_V5;
      ST_V5:      state_nxt = ST_P1;
      ST_P1:      state_nxt = ST_P2;
      ST_P2:      state_nxt = ST_DIV_MH;
      ST_DIV_MH:  state_nxt = ST_WAIT_MH;
      ST_WAIT_MH: if (!stat.busy) state_nxt = ST_DIV_VH;
      ST_DIV_VH:  state_nxt = ST_WAIT_VH;
      ST_WAIT_VH: if (!stat.busy) state_nxt = ST_SQRT;
      ST_SQRT:    state_nxt = ST_WAIT_SQ;
      ST_WAIT_SQ: if (!stat.busy) state_nxt = ST_DIV_Q;
      ST_DIV_Q:   state_nxt = ST_WAIT_Q;
      ST_WAIT_Q:  if (!stat.busy) state_nxt = ST_S1;
      ST_S1:      state_nxt = ST_S2;
      ST_S2:      state_nxt = ST_S3;
      ST_S3:      state_nxt = ST_WAIT_F;
      ST_WAIT_F:  if (!stat.busy) state_nxt = ST_UPD;
      ST_UPD:     if (out_free) state_nxt = ST_IDLE;
      ST_HOLD:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op        = OP_NONE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_ACCEPT;
      end
      ST_M1:      cmd.op = OP_M1;
      ST_M2:      cmd.op = OP_M2;
      ST_M3:      cmd.op = OP_M3;
      ST_G1:      cmd.op = OP_G1;
      ST_G2:      cmd.op = OP_G2;
      ST_G3:      cmd.op = OP_G3;
      ST_V1:      cmd.op = OP_V1;
      ST_V2:      cmd.op = OP_V2;
      ST_V3:      cmd.op = OP_V3;
      ST_V4:      cmd.op = OP_V4;
      ST_V5:      cmd.op = OP_V5;
      ST_P1:      cmd.op = OP_P1;
      ST_P2:      cmd.op = OP_P2;
      ST_DIV_MH:  cmd.op = OP_DIV_MH;
      ST_WAIT_MH: if (!stat.busy) cmd.op = OP_GET_MH;
      ST_DIV_VH:  cmd.op = OP_DIV_VH;
      ST_WAIT_VH: if (!stat.busy) cmd.op = OP_GET_VH;
      ST_SQRT:    cmd.op = OP_SQRT;
      ST_WAIT_SQ: if (!stat.busy) cmd.op = OP_GET_ROOT;
      ST_DIV_Q:   cmd.op = OP_DIV_Q;
      ST_WAIT_Q:  if (!stat.busy) cmd.op = OP_GET_Q;
      ST_S1:      cmd.op = OP_S1;
      ST_S2:      cmd.op = OP_S2;
      ST_S3:      cmd.op = OP_S3;
      ST_WAIT_F:  if (!stat.busy) cmd.op = OP_GET_F;
      ST_UPD: begin
        if (out_free) begin
          cmd.op        = OP_UPD;
          out_valid_nxt = 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.op        = OP_HOLD;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_upd_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_UPD || cmd.op == OP_HOLD) |-> out_free)
    else $error("result loaded over an untaken result");

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CHECK))
    else $error("accepted item not checked");

  a_unit_started: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_MH || state_r == ST_SQRT) |=> stat.busy)
    else $error("divide or root unit did not start");

endmodule

`default_nettype wire

### sv/adam_parameter_update.sv
// ----------------------------------------------------------------------------
// adam_parameter_update
// One Adam step of a single fixed-point parameter per input transaction.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready   tdata: gradient; tuser: restart
//   out_     out  out_tvalid/out_tready tdata: position, steps_taken;
//                                       tuser: converged, done_res
//   cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// An update's run time is set by the shared bit-serial unit, which works
// through three divisions (56, 48, 56 bits), one 24-bit division and a
// 32-bit root in turn. A transaction that arrives while the run is done
// skips the update and returns the held result. Reset is synchronous; no
// clearing pass. A waiting result does not block the next input; the update
// stalls before writing if the result is untaken.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_parameter_update (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // gradient
  input  wire logic [0:0]  in_tuser,   // restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // position, steps_taken
  output logic [1:0]       out_tuser,  // converged, done_res
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import apu_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] res_position;
  logic [15:0] res_steps;
  logic        res_converged, res_done;

  assign cfg_ready = 1'b1;

  apu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  apu_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid),
    .cfg_idx       (cfg_index),
    .cfg_wdata     (cfg_data),
    .in_grad       (in_tdata),
    .in_rst        (in_tuser[0]),
    .res_position  (res_position),
    .res_steps     (res_steps),
    .res_converged (res_converged),
    .res_done      (res_done)
  );

  assign out_tdata = {res_steps, res_position};
  assign out_tuser = {res_done, res_converged};

endmodule

`default_nettype wire
